[hw/rtl/sfr_pkg.sv]
// Package for the SBUS frame receiver: frame geometry, channel layout
// and the record that hands a finished frame from the assembler to the emitter.
// No dependencies.
package sfr_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES   = 25;
    localparam int POS_W         = 5;
    localparam int PAYLOAD_BYTES = 14;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;

    // Channel layout.
    localparam int NUM_CHANNELS = 10;
    localparam int CHAN_BITS    = 11;
    localparam int IDX_W        = 4;

    // Stream widths.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // Start-of-frame marker.
    localparam logic [7:0] START_BYTE = 8'h0F;

    // Position of the byte that completes a frame.
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // Index of the final channel in a burst.
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // A finished frame: bytes 1 to 14, byte 1 in the lowest bits.
    typedef struct packed {
        logic                    valid;
        logic [PAYLOAD_BITS-1:0] payload;
    } sfr_frame_t;

endpackage

[hw/rtl/sbus_frame_receiver.sv]
// Top level of the SBUS frame receiver: byte assembler plus channel emitter.
// Depends on sfr_pkg, sfr_assembler and sfr_emitter.
//
// The receiver takes one serial byte per cycle. It drops bytes until the
// start byte 0x0F, then counts the rest of a 25-byte frame without checking
// values, storing bytes 1 to 14. The completing byte starts a burst of ten
// results, channels 0 to 9 unpacked little-endian from those bytes, one per
// cycle while m_tready is high, the last marked by m_tlast. A frame passes the
// done register, then the busy and hold registers, before the result register.
// Bytes keep flowing during a burst; only a byte that would complete the next frame is held off (s_tready low)
// until the previous burst has left the emitter's frame hold register.
module sbus_frame_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfr_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfr_pkg::M_DATA_W-1:0]  m_tdata,   // [3:0] channel_index, [14:4] channel_value
    output logic                          m_tlast    // last_channel
);

    sfr_pkg::sfr_frame_t              frame;
    logic                             emit_busy;
    logic                             frame_blocked;
    logic                             byte_accept;
    logic [sfr_pkg::IDX_W-1:0]        out_index;
    logic [sfr_pkg::CHAN_BITS-1:0]    out_value;

    // Input handshake.
    assign s_tready    = !frame_blocked;
    assign byte_accept = s_tvalid && s_tready;

    sfr_assembler u_assembler (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_accept   (byte_accept),
        .rx_byte       (s_tdata),
        .emit_busy     (emit_busy),
        .frame_blocked (frame_blocked),
        .frame         (frame)
    );

    sfr_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frame     (frame),
        .busy      (emit_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    // Result packing, zero-filled to two bytes.
    assign m_tdata = {1'b0, out_value, out_index};

endmodule

[hw/rtl/sfr_assembler.sv]
// Byte assembler: hunts for the start byte, counts the frame and stores the
// channel payload bytes. Depends on sfr_pkg.
module sfr_assembler (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     byte_accept,
    input  logic [7:0]               rx_byte,
    input  logic                     emit_busy,
    output logic                     frame_blocked,
    output sfr_pkg::sfr_frame_t      frame
);

    logic [sfr_pkg::POS_W-1:0]        pos_reg;
    logic [sfr_pkg::POS_W-1:0]        pos_next;
    logic [sfr_pkg::PAYLOAD_BITS-1:0] store_reg;
    logic                             done_reg;
    logic                             done_next;

    // The completing byte must wait while the previous burst still drains.
    assign frame_blocked = (pos_reg == sfr_pkg::LAST_POS) && emit_busy;

    // Position counter: zero means hunting for the start byte.
    always_comb begin
        pos_next  = pos_reg;
        done_next = 1'b0;
        if (byte_accept) begin
            if (pos_reg == '0) begin
                if (rx_byte == sfr_pkg::START_BYTE) begin
                    pos_next = sfr_pkg::POS_W'(1);
                end
            end else if (pos_reg == sfr_pkg::LAST_POS) begin
                pos_next  = '0;
                done_next = 1'b1;
            end else begin
                pos_next = pos_reg + sfr_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // Payload store: byte positions 1 to 14 land in their own byte lanes.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < sfr_pkg::PAYLOAD_BYTES; i++) begin
            if (byte_accept && (pos_reg == sfr_pkg::POS_W'(i + 1))) begin
                store_reg[i*8 +: 8] <= rx_byte;
            end
        end
    end

    assign frame.valid   = done_reg;
    assign frame.payload = store_reg;

endmodule

[hw/rtl/sfr_emitter.sv]
// Channel emitter: holds a finished frame, unpacks one 11-bit channel per
// request and drives the result register. Depends on sfr_pkg.
module sfr_emitter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sfr_pkg::sfr_frame_t          frame,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sfr_pkg::IDX_W-1:0]    out_index,
    output logic [sfr_pkg::CHAN_BITS-1:0] out_value,
    output logic                         out_last
);

    logic [sfr_pkg::PAYLOAD_BITS-1:0] hold_reg;
    logic                             busy_reg;
    logic [sfr_pkg::IDX_W-1:0]        idx_reg;
    logic                             valid_reg;
    logic [sfr_pkg::IDX_W-1:0]        index_reg;
    logic [sfr_pkg::CHAN_BITS-1:0]    value_reg;
    logic                             last_reg;
    logic                             load_out;
    logic [sfr_pkg::CHAN_BITS-1:0]    chan_sel;

    // Move the next channel whenever the result register is free or drained.
    assign load_out = busy_reg && (!valid_reg || out_ready);

    // Channels are packed little-endian, eleven bits each, from frame byte 1.
    always_comb begin
        chan_sel = '0;
        for (int k = 0; k < sfr_pkg::NUM_CHANNELS; k++) begin
            if (idx_reg == sfr_pkg::IDX_W'(k)) begin
                chan_sel = hold_reg[k*sfr_pkg::CHAN_BITS +: sfr_pkg::CHAN_BITS];
            end
        end
    end

    // Burst control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (frame.valid) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (load_out) begin
                idx_reg <= idx_reg + sfr_pkg::IDX_W'(1);
                if (idx_reg == sfr_pkg::LAST_IDX) begin
                    busy_reg <= 1'b0;
                end
            end
            if (load_out) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Frame hold and result payload.
    always_ff @(posedge aclk) begin
        if (frame.valid) begin
            hold_reg <= frame.payload;
        end
        if (load_out) begin
            index_reg <= idx_reg;
            value_reg <= chan_sel;
            last_reg  <= (idx_reg == sfr_pkg::LAST_IDX);
        end
    end

    assign busy      = busy_reg;
    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule
